/* hdl/ota_pkg.sv */
// ----------------------------------------------------------------------------
// ota_pkg
// Shared types and constants for the update session checker: item layouts,
// frame and result codes, register defaults and session state.
// ----------------------------------------------------------------------------
package ota_pkg;

	// register defaults
	localparam logic [7:0]  CHUNK_MAX_RST     = 8'd166;
	localparam logic [4:0]  STEP_LOG2_RST     = 5'd12;
	localparam logic [15:0] IDLE_TIMEOUT_RST  = 16'd15000;
	localparam logic [15:0] REBOOT_DELAY_RST  = 16'd1500;

	// result queue depth (two results per item must fit)
	localparam int unsigned QUEUE_DEPTH = 4;

	// register indexes
	localparam logic [1:0] REG_CHUNK_MAX    = 2'd0;
	localparam logic [1:0] REG_STEP_LOG2    = 2'd1;
	localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd2;
	localparam logic [1:0] REG_REBOOT_DELAY = 2'd3;

	// input actions, also used as acknowledged frame kind
	localparam logic [1:0] ACT_BEGIN  = 2'd0;
	localparam logic [1:0] ACT_CHUNK  = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;
	localparam logic [1:0] ACT_TICK   = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_REBOOT = 2'd2;

	// acknowledge codes
	localparam logic [7:0] ACK_OK     = 8'd0;
	localparam logic [7:0] ACK_PROTO  = 8'd1;
	localparam logic [7:0] ACK_BADARG = 8'd2;
	localparam logic [7:0] ACK_SIZE   = 8'd3;
	localparam logic [7:0] ACK_UPDATE = 8'd4;

	// bytes of the leading payload word
	localparam logic [7:0] WORD_BYTES = 8'd4;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  session;
		logic [7:0]  seq;
		logic [7:0]  payload_len;
		logic [31:0] word;
		logic        connected;
		logic        flash_ok;
		logic        flash_running;
		logic [7:0]  flash_err;
	} frame_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  session_out;
		logic [7:0]  seq_out;
		logic [1:0]  frame_kind;
		logic [7:0]  code;
		logic [31:0] progress;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [7:0]  chunk_max;
		logic [4:0]  progress_step_log2;
		logic [15:0] idle_timeout;
		logic [15:0] reboot_delay;
	} cfg_t;

	typedef struct packed {
		logic        active;
		logic [7:0]  cur_session;
		logic [31:0] total_len;
		logic [31:0] expected_offset;
		logic [31:0] last_progress;
		logic [15:0] idle_ticks;
		logic        reboot_pending;
		logic [15:0] reboot_count;
	} sess_t;

	// results of one item: count 0..2, first and second in order
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} emit_t;

endpackage

/* hdl/ota_rsq.sv */
// ----------------------------------------------------------------------------
// ota_rsq
// Result queue: takes up to two results per cycle, hands out one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ota_rsq #(
	parameter int unsigned Depth = ota_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ota_pkg::emit_t    emit,
	output logic              room,
	output logic              result_valid,
	input  logic              result_stall,
	output ota_pkg::result_t  result
);

	localparam int unsigned PW = $clog2(Depth);
	localparam int unsigned CW = $clog2(Depth + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(Depth - 1);

	ota_pkg::result_t mem [Depth];

	logic [PW-1:0] wr_q, rd_q, wr_next, wr_after, rd_next;
	logic [CW-1:0] count_q;
	logic [1:0]    push_n;
	logic          pop;

	assign push_n   = push ? emit.count : 2'd0;
	assign pop      = result_valid && !result_stall;
	assign wr_next  = (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
	assign wr_after = (wr_next == PTR_LAST) ? '0 : wr_next + 1'b1;
	assign rd_next  = (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;

	assign room         = (count_q <= CW'(Depth - 2));
	assign result_valid = (count_q != '0);
	assign result       = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_q] <= emit.first;
		end
		if (push_n == 2'd2) begin
			mem[wr_next] <= emit.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			unique case (push_n)
				2'd1:    wr_q <= wr_next;
				2'd2:    wr_q <= wr_after;
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= rd_next;
			end
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(Depth))
		else $error("result queue overfilled");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (rd_q == wr_q))
		else $error("empty queue with pointers apart");

endmodule

/* hdl/ota_core.sv */
// ----------------------------------------------------------------------------
// ota_core
// Session state and per-item decision logic: checks one registered frame or
// tick, updates the session and forms up to two result items.
// ----------------------------------------------------------------------------
module ota_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  ota_pkg::frame_t  item,
	input  ota_pkg::cfg_t    cfg,
	output ota_pkg::emit_t   emit
);

	ota_pkg::sess_t   sess_q, sess_d;
	ota_pkg::result_t status_r, ack_r, reboot_r;

	logic [7:0]  code, status_code, err_code, len;
	logic [31:0] status_prog, step_mask;
	logic [32:0] chunk_end;
	logic [15:0] count_dec;
	logic        status_en, ack_en, reboot_en, crossed, frame_bad;

	assign len       = item.payload_len - ota_pkg::WORD_BYTES;
	assign chunk_end = {1'b0, item.word} + {25'd0, len};
	assign step_mask = {32{1'b1}} << cfg.progress_step_log2;
	assign crossed   = (((chunk_end[31:0] ^ sess_q.last_progress) & step_mask) != '0);
	assign err_code  = (item.flash_err != 8'd0) ? item.flash_err : ota_pkg::ACK_UPDATE;
	assign count_dec = (sess_q.reboot_count != 16'd0) ? sess_q.reboot_count - 16'd1 : 16'd0;
	// chunk and finish share the session/length screen
	assign frame_bad = !sess_q.active || (item.session != sess_q.cur_session)
		|| (item.payload_len < ota_pkg::WORD_BYTES);

	always_comb begin
		sess_d      = sess_q;
		code        = ota_pkg::ACK_OK;
		status_en   = 1'b0;
		status_code = 8'd0;
		status_prog = 32'd0;
		ack_en      = 1'b0;
		reboot_en   = 1'b0;
		unique case (item.action)
			ota_pkg::ACT_TICK: begin
				if (!item.connected) begin
					if (sess_q.active) begin
						sess_d = '0;
					end
				end else begin
					if (sess_q.active && !sess_q.reboot_pending) begin
						if (sess_q.idle_ticks >= cfg.idle_timeout) begin
							sess_d = '0;
						end else begin
							sess_d.idle_ticks = sess_q.idle_ticks + 16'd1;
						end
					end
					if (sess_q.reboot_pending) begin
						sess_d.reboot_count = count_dec;
						if (count_dec == 16'd0) begin
							reboot_en = 1'b1;
							sess_d    = '0;
						end
					end
				end
			end
			ota_pkg::ACT_BEGIN: begin
				ack_en = 1'b1;
				if (item.payload_len < ota_pkg::WORD_BYTES) begin
					code = ota_pkg::ACK_PROTO;
				end else if (item.word == 32'd0) begin
					code = ota_pkg::ACK_BADARG;
				end else begin
					sess_d = '0;
					if (!item.connected) begin
						code = ota_pkg::ACK_PROTO;
					end else if (!item.flash_ok) begin
						status_en   = 1'b1;
						status_code = err_code;
						code        = ota_pkg::ACK_UPDATE;
					end else begin
						sess_d.active      = 1'b1;
						sess_d.cur_session = item.session;
						sess_d.total_len   = item.word;
					end
				end
			end
			ota_pkg::ACT_CHUNK: begin
				ack_en = 1'b1;
				if (frame_bad) begin
					code = ota_pkg::ACK_PROTO;
				end else begin
					sess_d.idle_ticks = 16'd0;
					if (len == 8'd0) begin
						code = ota_pkg::ACK_BADARG;
					end else if (len > cfg.chunk_max) begin
						code = ota_pkg::ACK_SIZE;
					end else if (item.word != sess_q.expected_offset) begin
						code = ota_pkg::ACK_PROTO;
					end else if (chunk_end > {1'b0, sess_q.total_len}) begin
						code = ota_pkg::ACK_SIZE;
					end else if (!item.flash_running) begin
						code = ota_pkg::ACK_PROTO;
					end else if (!item.flash_ok) begin
						sess_d      = '0;
						status_en   = 1'b1;
						status_code = err_code;
						status_prog = sess_q.expected_offset;
						code        = ota_pkg::ACK_UPDATE;
					end else begin
						sess_d.expected_offset = chunk_end[31:0];
						if ((chunk_end[31:0] == sess_q.total_len) || crossed) begin
							sess_d.last_progress = chunk_end[31:0];
							status_en            = 1'b1;
							status_prog          = chunk_end[31:0];
						end
					end
				end
			end
			default: begin
				// finish frame
				ack_en = 1'b1;
				if (frame_bad) begin
					code = ota_pkg::ACK_PROTO;
				end else if (item.word != sess_q.total_len) begin
					code = ota_pkg::ACK_SIZE;
				end else if (sess_q.expected_offset != sess_q.total_len) begin
					code = ota_pkg::ACK_PROTO;
				end else if (!item.flash_running) begin
					code = ota_pkg::ACK_PROTO;
				end else if (!item.flash_ok) begin
					status_en   = 1'b1;
					status_code = err_code;
					status_prog = sess_q.expected_offset;
					code        = ota_pkg::ACK_UPDATE;
				end else begin
					status_en             = 1'b1;
					status_prog           = sess_q.total_len;
					sess_d.reboot_pending = 1'b1;
					sess_d.reboot_count   = cfg.reboot_delay;
				end
				if (code != ota_pkg::ACK_OK) begin
					sess_d = '0;
				end
			end
		endcase
	end

	always_comb begin
		status_r.kind        = ota_pkg::KIND_STATUS;
		status_r.session_out = item.session;
		status_r.seq_out     = item.seq + 8'd1;
		status_r.frame_kind  = item.action;
		status_r.code        = status_code;
		status_r.progress    = status_prog;
		status_r.last        = 1'b0;

		ack_r.kind        = ota_pkg::KIND_ACK;
		ack_r.session_out = item.session;
		ack_r.seq_out     = item.seq;
		ack_r.frame_kind  = item.action;
		ack_r.code        = code;
		ack_r.progress    = 32'd0;
		ack_r.last        = 1'b1;

		reboot_r      = '0;
		reboot_r.kind = ota_pkg::KIND_REBOOT;
		reboot_r.last = 1'b1;

		emit.count  = {1'b0, status_en} + {1'b0, ack_en} + {1'b0, reboot_en};
		emit.first  = status_en ? status_r : (ack_en ? ack_r : reboot_r);
		emit.second = ack_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_q <= '0;
		end else if (fire) begin
			sess_q <= sess_d;
		end
	end

	a_pending_active: assert property (@(posedge clk) disable iff (!arst_n)
		sess_q.reboot_pending |-> sess_q.active)
		else $error("reboot pending without a session");

	a_offset_in_total: assert property (@(posedge clk) disable iff (!arst_n)
		sess_q.active |-> (sess_q.expected_offset <= sess_q.total_len))
		else $error("offset beyond total length");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!sess_q.active |-> (sess_q.total_len == 32'd0 && sess_q.expected_offset == 32'd0
			&& sess_q.idle_ticks == 16'd0))
		else $error("stale state without a session");

endmodule

/* hdl/ota_session_checker.sv */
// ----------------------------------------------------------------------------
// ota_session_checker
// Receiver side of a firmware update session: checks begin, chunk and finish
// frames, tracks progress and timeouts on ticks, and issues acknowledge,
// status and reboot request items.
// ----------------------------------------------------------------------------
// Order: an accepted item is registered, then decided once the result queue
//   has room for two results; its results enter the queue then and are offered from it.
// Throughput: one item per cycle while results drain; the result port moves
//   one result per cycle unless stalled, so items with two results can stall the input.
// Reset: session state cleared, registers at defaults, result queue empty.
// ----------------------------------------------------------------------------
module ota_session_checker #(
	parameter int unsigned QueueDepth = ota_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	// frames and ticks
	input  logic              frame_valid,
	output logic              frame_stall,
	input  ota_pkg::frame_t   frame,
	// acknowledge, status and reboot items
	output logic              result_valid,
	input  logic              result_stall,
	output ota_pkg::result_t  result,
	// register writes
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	ota_pkg::frame_t item_s1;
	ota_pkg::cfg_t   cfg_q;
	ota_pkg::emit_t  emit;
	logic            valid_s1;
	logic            room;
	logic            fire;
	logic            accept;

	// The held item is decided once the queue has space for two results.
	// Stall only while a held item waits for that space.
	assign fire        = valid_s1 && room;
	assign frame_stall = valid_s1 && !room;
	assign accept      = frame_valid && !frame_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= frame;
		end
	end

	// Registers; the user must write them only while no item is in flight; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chunk_max          <= ota_pkg::CHUNK_MAX_RST;
			cfg_q.progress_step_log2 <= ota_pkg::STEP_LOG2_RST;
			cfg_q.idle_timeout       <= ota_pkg::IDLE_TIMEOUT_RST;
			cfg_q.reboot_delay       <= ota_pkg::REBOOT_DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ota_pkg::REG_CHUNK_MAX:    cfg_q.chunk_max          <= cfg_data[7:0];
				ota_pkg::REG_STEP_LOG2:    cfg_q.progress_step_log2 <= cfg_data[4:0];
				ota_pkg::REG_IDLE_TIMEOUT: cfg_q.idle_timeout       <= cfg_data;
				ota_pkg::REG_REBOOT_DELAY: cfg_q.reboot_delay       <= cfg_data;
			endcase
		end
	end

	// Decision logic and session state
	ota_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.emit   (emit)
	);

	// Results wait here so the input side keeps moving
	ota_rsq #(
		.Depth (QueueDepth)
	) u_rsq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (fire),
		.emit         (emit),
		.room         (room),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* verif/ota_session_checker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ota_session_checker testbench
// Drives begin, chunk, finish and tick items into the session checker, with
// random gaps on both sides and long result hold-offs. A behavioral copy
// of the session logic predicts every acknowledge, status and reboot item,
// and each delivered result is checked field by field against it. A short
// table of directed items runs first, then several random phases under
// different register settings, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;

	// generous bound on the whole run, in clock cycles
	localparam int CYCLE_LIMIT = 400000;
	// length of each long result hold-off
	localparam int HOLD_CYCLES = 80;
	// random items per register setting
	localparam int PHASE_ITEMS = 300;
	localparam int PHASE_COUNT = 6;

	// one row of the directed table; pin marks a row whose acknowledge code
	// is typed in, reconfig asks for the directed register setting first
	typedef struct packed {
		ota_pkg::frame_t f;
		logic            pin;
		logic [7:0]      code;
		logic            reconfig;
	} plan_row_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             frame_valid;
	logic             frame_stall;
	ota_pkg::frame_t  frame;
	logic             result_valid;
	logic             result_stall;
	ota_pkg::result_t result;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [15:0]      cfg_data;

	// shadow of the session state, advanced on each accepted item, and of the registers
	ota_pkg::sess_t   sess = '0;
	ota_pkg::cfg_t    cfg;
	ota_pkg::result_t pending_results[$];
	plan_row_t        plan[$];

	// typed acknowledge code that rides along with the item on the wire
	logic        pin_ack;
	logic [7:0]  pin_code;

	logic        idle_on;
	int          holds_asked = 0;
	int          tick_burst = 0;
	int          cycle_count = 0;
	int          mismatches = 0;
	int          items_taken = 0;
	int          acks_seen = 0;
	int          status_seen = 0;
	int          reboots_seen = 0;

	ota_session_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame        (frame),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// ------------------------------------------------------------------
	// session prediction
	// ------------------------------------------------------------------
	function automatic ota_pkg::result_t compose(input logic [1:0] kind,
			input logic [7:0] ses, input logic [7:0] seq, input logic [1:0] fk,
			input logic [7:0] code, input logic [31:0] prog);
		ota_pkg::result_t r;
		r.kind        = kind;
		r.session_out = ses;
		r.seq_out     = seq;
		r.frame_kind  = fk;
		r.code        = code;
		r.progress    = prog;
		r.last        = 1'b0;
		return r;
	endfunction

	// a flash failure reports the engine code, or the update code if it has none
	function automatic logic [7:0] flash_fail_code(input logic [7:0] err);
		return (err != 8'd0) ? err : ota_pkg::ACK_UPDATE;
	endfunction

	// advance the shadow session by one item and queue what it must emit
	task automatic predict_session(input ota_pkg::frame_t f);
		ota_pkg::result_t outs[2];
		int          n;
		logic [7:0]  code;
		logic [7:0]  sseq;
		logic [7:0]  len;
		logic [32:0] reach;
		logic [31:0] prog;
		logic [4:0]  sh;
		n    = 0;
		code = ota_pkg::ACK_OK;
		sseq = f.seq + 8'd1;
		sh   = cfg.progress_step_log2;
		if (f.action == ota_pkg::ACT_TICK) begin
			if (!f.connected) begin
				// link lost: drop the session, say nothing
				if (sess.active)
					sess = '0;
			end else begin
				if (sess.active && !sess.reboot_pending) begin
					if (sess.idle_ticks >= cfg.idle_timeout)
						sess = '0;
					else
						sess.idle_ticks = sess.idle_ticks + 16'd1;
				end
				if (sess.reboot_pending) begin
					if (sess.reboot_count != 16'd0)
						sess.reboot_count = sess.reboot_count - 16'd1;
					if (sess.reboot_count == 16'd0) begin
						outs[0] = compose(ota_pkg::KIND_REBOOT, 8'd0, 8'd0,
							ota_pkg::ACT_BEGIN, ota_pkg::ACK_OK, 32'd0);
						n = 1;
						sess = '0;
					end
				end
			end
		end else begin
			if (f.action == ota_pkg::ACT_BEGIN) begin
				if (f.payload_len < ota_pkg::WORD_BYTES)
					code = ota_pkg::ACK_PROTO;
				else if (f.word == 32'd0)
					code = ota_pkg::ACK_BADARG;
				else begin
					// a well-formed begin drops the old session first
					if (sess.active)
						sess = '0;
					if (!f.connected)
						code = ota_pkg::ACK_PROTO;
					else if (!f.flash_ok) begin
						sess = '0;
						outs[n] = compose(ota_pkg::KIND_STATUS, f.session, sseq,
							ota_pkg::ACT_BEGIN, flash_fail_code(f.flash_err), 32'd0);
						n++;
						code = ota_pkg::ACK_UPDATE;
					end else begin
						sess.active          = 1'b1;
						sess.cur_session     = f.session;
						sess.total_len       = f.word;
						sess.expected_offset = 32'd0;
						sess.last_progress   = 32'd0;
						sess.idle_ticks      = 16'd0;
					end
				end
			end else if (f.action == ota_pkg::ACT_CHUNK) begin
				if (!sess.active || f.session != sess.cur_session
						|| f.payload_len < ota_pkg::WORD_BYTES)
					code = ota_pkg::ACK_PROTO;
				else begin
					len = f.payload_len - ota_pkg::WORD_BYTES;
					sess.idle_ticks = 16'd0;
					// overrun is judged on 33 bits, no wrap
					reach = {1'b0, f.word} + {25'd0, len};
					if (len == 8'd0)
						code = ota_pkg::ACK_BADARG;
					else if (len > cfg.chunk_max)
						code = ota_pkg::ACK_SIZE;
					else if (f.word != sess.expected_offset)
						code = ota_pkg::ACK_PROTO;
					else if (reach > {1'b0, sess.total_len})
						code = ota_pkg::ACK_SIZE;
					else if (!f.flash_running)
						code = ota_pkg::ACK_PROTO;
					else if (!f.flash_ok) begin
						// failure status carries the offset before this chunk
						prog = sess.expected_offset;
						sess = '0;
						outs[n] = compose(ota_pkg::KIND_STATUS, f.session, sseq,
							ota_pkg::ACT_CHUNK, flash_fail_code(f.flash_err), prog);
						n++;
						code = ota_pkg::ACK_UPDATE;
					end else begin
						prog = sess.expected_offset + {24'd0, len};
						sess.expected_offset = prog;
						if (prog == sess.total_len ||
								(prog >> sh) != (sess.last_progress >> sh)) begin
							sess.last_progress = prog;
							outs[n] = compose(ota_pkg::KIND_STATUS, f.session, sseq,
								ota_pkg::ACT_CHUNK, ota_pkg::ACK_OK, prog);
							n++;
						end
					end
				end
			end else begin
				if (!sess.active || f.session != sess.cur_session
						|| f.payload_len < ota_pkg::WORD_BYTES)
					code = ota_pkg::ACK_PROTO;
				else if (f.word != sess.total_len)
					code = ota_pkg::ACK_SIZE;
				else if (sess.expected_offset != sess.total_len)
					code = ota_pkg::ACK_PROTO;
				else if (!f.flash_running)
					code = ota_pkg::ACK_PROTO;
				else if (!f.flash_ok) begin
					outs[n] = compose(ota_pkg::KIND_STATUS, f.session, sseq,
						ota_pkg::ACT_FINISH, flash_fail_code(f.flash_err),
						sess.expected_offset);
					n++;
					code = ota_pkg::ACK_UPDATE;
				end else begin
					outs[n] = compose(ota_pkg::KIND_STATUS, f.session, sseq,
						ota_pkg::ACT_FINISH, ota_pkg::ACK_OK, sess.total_len);
					n++;
					sess.reboot_pending = 1'b1;
					sess.reboot_count   = cfg.reboot_delay;
				end
				// any finish that is not ok ends the session
				if (code != ota_pkg::ACK_OK)
					sess = '0;
			end
			outs[n] = compose(ota_pkg::KIND_ACK, f.session, f.seq, f.action, code, 32'd0);
			n++;
		end
		for (int i = 0; i < n; i++) begin
			outs[i].last = (i == n - 1);
			pending_results.push_back(outs[i]);
		end
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 40)
			$display("mismatch at %0d ns: %s got 0x%0h expected 0x%0h",
				$time, what, got, want);
		mismatches++;
	endtask

	task automatic check_result(input ota_pkg::result_t got);
		ota_pkg::result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result with nothing pending, kind", 32'(got.kind), 32'd0);
		end else begin
			want = pending_results.pop_front();
			if (got.kind !== want.kind)
				report_mismatch("kind", 32'(got.kind), 32'(want.kind));
			if (got.session_out !== want.session_out)
				report_mismatch("session_out", 32'(got.session_out), 32'(want.session_out));
			if (got.seq_out !== want.seq_out)
				report_mismatch("seq_out", 32'(got.seq_out), 32'(want.seq_out));
			if (got.frame_kind !== want.frame_kind)
				report_mismatch("frame_kind", 32'(got.frame_kind), 32'(want.frame_kind));
			if (got.code !== want.code)
				report_mismatch("code", 32'(got.code), 32'(want.code));
			if (got.progress !== want.progress)
				report_mismatch("progress", got.progress, want.progress);
			if (got.last !== want.last)
				report_mismatch("last", 32'(got.last), 32'(want.last));
			if (want.kind == ota_pkg::KIND_ACK)
				acks_seen++;
			else if (want.kind == ota_pkg::KIND_STATUS)
				status_seen++;
			else
				reboots_seen++;
		end
	endtask

	// both handshakes sampled at the rising edge; results of an item accepted
	// here pass the held item register and the result queue first, so the order is safe
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall)
				check_result(result);
			if (frame_valid && !frame_stall) begin
				predict_session(frame);
				items_taken++;
				if (pin_ack && pending_results.size() != 0) begin
					// typed-in acknowledge code replaces the predicted one
					ota_pkg::result_t ack;
					ack = pending_results.pop_back();
					ack.code = pin_code;
					pending_results.push_back(ack);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// driving; every task here starts and ends just after a falling edge
	// ------------------------------------------------------------------
	task automatic send_item(input ota_pkg::frame_t f, input logic pin,
			input logic [7:0] code);
		while (idle_on && $urandom_range(99) < 25) begin
			frame_valid = 1'b0;
			@(negedge clk);
		end
		frame       = f;
		pin_ack     = pin;
		pin_code    = code;
		frame_valid = 1'b1;
		do @(posedge clk); while (frame_stall);
		@(negedge clk);
	endtask

	task automatic apply_config(input ota_pkg::cfg_t c);
		cfg_we    = 1'b1;
		cfg_index = ota_pkg::REG_CHUNK_MAX;
		cfg_data  = {8'd0, c.chunk_max};
		@(negedge clk);
		cfg_index = ota_pkg::REG_STEP_LOG2;
		cfg_data  = {11'd0, c.progress_step_log2};
		@(negedge clk);
		cfg_index = ota_pkg::REG_IDLE_TIMEOUT;
		cfg_data  = c.idle_timeout;
		@(negedge clk);
		cfg_index = ota_pkg::REG_REBOOT_DELAY;
		cfg_data  = c.reboot_delay;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg    = c;
	endtask

	// all results home, then let a trailing tick settle
	task automatic wait_quiet();
		frame_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic ota_pkg::frame_t make_frame(input logic [1:0] act,
			input logic [7:0] ses, input logic [7:0] seq, input logic [7:0] plen,
			input logic [31:0] w, input logic conn, input logic ok, input logic run,
			input logic [7:0] err);
		ota_pkg::frame_t f;
		f.action        = act;
		f.session       = ses;
		f.seq           = seq;
		f.payload_len   = plen;
		f.word          = w;
		f.connected     = conn;
		f.flash_ok      = ok;
		f.flash_running = run;
		f.flash_err     = err;
		return f;
	endfunction

	task automatic add_row(input ota_pkg::frame_t f, input logic pin,
			input logic [7:0] code, input logic reconfig);
		plan_row_t r;
		r.f        = f;
		r.pin      = pin;
		r.code     = code;
		r.reconfig = reconfig;
		plan.push_back(r);
	endtask

	task automatic load_plan();
		// at reset values: rejection paths of begin and chunk
		add_row(make_frame(ota_pkg::ACT_TICK, 8'h00, 8'h00, 8'd0, 32'd0,
			1'b1, 1'b0, 1'b0, 8'h00), 1'b0, ota_pkg::ACK_OK, 1'b0);
		add_row(make_frame(ota_pkg::ACT_CHUNK, 8'h00, 8'h01, 8'd8, 32'd0,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_PROTO, 1'b0);
		add_row(make_frame(ota_pkg::ACT_BEGIN, 8'h10, 8'h03, 8'd3, 32'd1000,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_PROTO, 1'b0);
		add_row(make_frame(ota_pkg::ACT_BEGIN, 8'h10, 8'h04, 8'd4, 32'd0,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_BADARG, 1'b0);
		add_row(make_frame(ota_pkg::ACT_BEGIN, 8'h10, 8'h05, 8'd8, 32'd5000,
			1'b0, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_PROTO, 1'b0);
		// flash begin fails, with and without an engine code
		add_row(make_frame(ota_pkg::ACT_BEGIN, 8'h11, 8'h06, 8'd8, 32'd5000,
			1'b1, 1'b0, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_UPDATE, 1'b0);
		add_row(make_frame(ota_pkg::ACT_BEGIN, 8'h12, 8'h07, 8'd255, 32'd5000,
			1'b1, 1'b0, 1'b0, 8'hFF), 1'b1, ota_pkg::ACK_UPDATE, 1'b0);
		add_row(make_frame(ota_pkg::ACT_BEGIN, 8'hFF, 8'hFF, 8'd8, 32'd5000,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_OK, 1'b0);
		add_row(make_frame(ota_pkg::ACT_CHUNK, 8'hFF, 8'h00, 8'd4, 32'd0,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_BADARG, 1'b0);
		// one byte over the default chunk limit, then exactly at it
		add_row(make_frame(ota_pkg::ACT_CHUNK, 8'hFF, 8'h01, 8'd171, 32'd0,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_SIZE, 1'b0);
		add_row(make_frame(ota_pkg::ACT_CHUNK, 8'hFF, 8'h03, 8'd170, 32'd1,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_PROTO, 1'b0);
		add_row(make_frame(ota_pkg::ACT_CHUNK, 8'hFF, 8'h04, 8'd170, 32'd0,
			1'b1, 1'b1, 1'b0, 8'h00), 1'b1, ota_pkg::ACK_PROTO, 1'b0);
		add_row(make_frame(ota_pkg::ACT_CHUNK, 8'hFF, 8'h05, 8'd170, 32'd0,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_OK, 1'b0);
		// flash write fails mid session; status seq wraps to zero
		add_row(make_frame(ota_pkg::ACT_CHUNK, 8'hFF, 8'hFF, 8'd170, 32'd166,
			1'b1, 1'b0, 1'b1, 8'h03), 1'b1, ota_pkg::ACK_UPDATE, 1'b0);
		// extreme registers: widest chunk, coarsest step, shortest idle, no delay
		add_row(make_frame(ota_pkg::ACT_BEGIN, 8'h5A, 8'h10, 8'd4, 32'hFFFFFFFF,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_OK, 1'b1);
		add_row(make_frame(ota_pkg::ACT_CHUNK, 8'h5A, 8'h11, 8'd255, 32'd0,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b0, ota_pkg::ACK_OK, 1'b0);
		// second tick reaches the idle limit and drops the session
		add_row(make_frame(ota_pkg::ACT_TICK, 8'h00, 8'h00, 8'd0, 32'd0,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b0, ota_pkg::ACK_OK, 1'b0);
		add_row(make_frame(ota_pkg::ACT_TICK, 8'h00, 8'h00, 8'd0, 32'd0,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b0, ota_pkg::ACK_OK, 1'b0);
		add_row(make_frame(ota_pkg::ACT_CHUNK, 8'h5A, 8'h12, 8'd255, 32'd251,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_PROTO, 1'b0);
		// complete session, then the reboot request on the first tick
		add_row(make_frame(ota_pkg::ACT_BEGIN, 8'h5A, 8'h13, 8'd8, 32'd10,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_OK, 1'b0);
		add_row(make_frame(ota_pkg::ACT_CHUNK, 8'h5A, 8'h14, 8'd14, 32'd0,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b0, ota_pkg::ACK_OK, 1'b0);
		add_row(make_frame(ota_pkg::ACT_FINISH, 8'h5A, 8'h15, 8'd8, 32'd10,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_OK, 1'b0);
		add_row(make_frame(ota_pkg::ACT_TICK, 8'h00, 8'h00, 8'd0, 32'd0,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b0, ota_pkg::ACK_OK, 1'b0);
		// disconnected tick drops a live session silently
		add_row(make_frame(ota_pkg::ACT_BEGIN, 8'h5A, 8'h16, 8'd8, 32'd10,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_OK, 1'b0);
		add_row(make_frame(ota_pkg::ACT_TICK, 8'h00, 8'h00, 8'd0, 32'd0,
			1'b0, 1'b1, 1'b1, 8'h00), 1'b0, ota_pkg::ACK_OK, 1'b0);
		add_row(make_frame(ota_pkg::ACT_CHUNK, 8'h5A, 8'h17, 8'd14, 32'd0,
			1'b1, 1'b1, 1'b1, 8'h00), 1'b1, ota_pkg::ACK_PROTO, 1'b0);
	endtask

	function automatic ota_pkg::frame_t noise_frame();
		ota_pkg::frame_t f;
		f.action        = 2'($urandom_range(3));
		f.session       = 8'($urandom);
		f.seq           = 8'($urandom);
		f.payload_len   = 8'($urandom);
		f.word          = $urandom;
		f.connected     = 1'($urandom);
		f.flash_ok      = 1'($urandom);
		f.flash_running = 1'($urandom);
		f.flash_err     = 8'($urandom);
		return f;
	endfunction

	// mostly well-formed sessions that follow the shadow state, with noise,
	// stray ticks, bursts of ticks for idle timeouts and broken frames mixed in
	task automatic next_random(output ota_pkg::frame_t f);
		int          pick;
		int          cap;
		int          span;
		logic [31:0] room;
		pick = $urandom_range(99);
		f = noise_frame();
		span = (cfg.chunk_max > 8'd251) ? 251 : int'(cfg.chunk_max);
		if (tick_burst > 0) begin
			tick_burst--;
			f.action    = ota_pkg::ACT_TICK;
			f.connected = 1'b1;
		end else if (pick < 15) begin
			// raw noise, every field random
		end else if (pick < 27) begin
			f.action    = ota_pkg::ACT_TICK;
			f.connected = ($urandom_range(49) != 0);
		end else if (!sess.active) begin
			f.action      = ota_pkg::ACT_BEGIN;
			f.payload_len = 8'($urandom_range(4, 255));
			if ($urandom_range(9) != 0)
				f.word = 32'($urandom_range(1, span * 8));
			f.connected = ($urandom_range(19) != 0);
			f.flash_ok  = ($urandom_range(11) != 0);
		end else if (sess.reboot_pending) begin
			// ride out the reboot delay, now and then start over
			if ($urandom_range(99) < 85) begin
				f.action    = ota_pkg::ACT_TICK;
				f.connected = 1'b1;
			end else begin
				f.action      = ota_pkg::ACT_BEGIN;
				f.payload_len = 8'($urandom_range(4, 255));
				f.word        = 32'($urandom_range(1, span * 8));
			end
		end else if (sess.expected_offset != sess.total_len) begin
			f.action = ota_pkg::ACT_CHUNK;
			if ($urandom_range(19) != 0)
				f.session = sess.cur_session;
			if ($urandom_range(19) != 0)
				f.word = sess.expected_offset;
			cap  = span;
			room = sess.total_len - sess.expected_offset;
			if (room < 32'(cap))
				cap = int'(room);
			if ($urandom_range(99) < 93)
				f.payload_len = 8'($urandom_range(1, cap) + 4);
			f.flash_running = ($urandom_range(29) != 0);
			f.flash_ok      = ($urandom_range(24) != 0);
			if (cfg.idle_timeout <= 16'd40 && $urandom_range(99) < 3)
				tick_burst = int'(cfg.idle_timeout) + 2;
		end else begin
			f.action = ota_pkg::ACT_FINISH;
			if ($urandom_range(19) != 0)
				f.session = sess.cur_session;
			if ($urandom_range(19) != 0)
				f.word = sess.total_len;
			f.payload_len   = 8'($urandom_range(4, 255));
			f.flash_running = ($urandom_range(29) != 0);
			f.flash_ok      = ($urandom_range(11) != 0);
		end
	endtask

	// result side: random stalls, or one long hold-off when asked, so that the
	// result queue fills and the block has to stall its input
	initial begin
		int held;
		int holds_done;
		holds_done   = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_asked != holds_done) begin
				holds_done++;
				result_stall = 1'b1;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
			end else begin
				result_stall = idle_on && ($urandom_range(99) < 25);
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still pending",
			cycle_count, pending_results.size());
		$display("[ota_session_checker] ERROR");
		$finish;
	end

	initial begin
		ota_pkg::cfg_t   next_cfg;
		ota_pkg::frame_t f;
		int              spin;
		frame_valid = 1'b0;
		frame       = '0;
		pin_ack     = 1'b0;
		pin_code    = ota_pkg::ACK_OK;
		cfg_we      = 1'b0;
		cfg_index   = ota_pkg::REG_CHUNK_MAX;
		cfg_data    = '0;
		idle_on     = 1'b1;
		cfg  = {ota_pkg::CHUNK_MAX_RST, ota_pkg::STEP_LOG2_RST,
			ota_pkg::IDLE_TIMEOUT_RST, ota_pkg::REBOOT_DELAY_RST};
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table; the later rows run under extreme registers
		load_plan();
		foreach (plan[i]) begin
			if (plan[i].reconfig) begin
				wait_quiet();
				apply_config({8'd255, 5'd24, 16'd1, 16'd0});
			end
			send_item(plan[i].f, plan[i].pin, plan[i].code);
		end

		// random phases: reset values, both extremes, then random settings;
		// phase four runs with no idling on either side
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			wait_quiet();
			unique case (ph)
				0: next_cfg = {ota_pkg::CHUNK_MAX_RST, ota_pkg::STEP_LOG2_RST,
					ota_pkg::IDLE_TIMEOUT_RST, ota_pkg::REBOOT_DELAY_RST};
				1: next_cfg = {8'd255, 5'd0, 16'd1, 16'd0};
				2: next_cfg = {8'd1, 5'd24, 16'hFFFF, 16'hFFFF};
				default: begin
					next_cfg.chunk_max          = 8'($urandom_range(1, 255));
					next_cfg.progress_step_log2 = 5'($urandom_range(0, 16));
					next_cfg.idle_timeout       = 16'($urandom_range(1, 40));
					next_cfg.reboot_delay       = 16'($urandom_range(0, 25));
				end
			endcase
			apply_config(next_cfg);
			tick_burst = 0;
			idle_on = (ph != 4);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ((ph == 1 || ph == 3) && k == PHASE_ITEMS / 3)
					holds_asked++;
				next_random(f);
				send_item(f, 1'b0, ota_pkg::ACK_OK);
			end
		end

		// drain, then allow the block a little longer to show anything extra
		frame_valid = 1'b0;
		for (spin = 0; spin < 2000 && pending_results.size() != 0; spin++)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered, count",
				32'(pending_results.size()), 32'd0);

		$display("run covered %0d items in %0d cycles under %0d register settings",
			items_taken, cycle_count, PHASE_COUNT + 2);
		$display("checked %0d acknowledges, %0d status items, %0d reboot requests, %0d mismatches",
			acks_seen, status_seen, reboots_seen, mismatches);
		if (mismatches == 0)
			$display("[ota_session_checker] OK");
		else
			$display("[ota_session_checker] ERROR");
		$finish;
	end

endmodule

/* ota_session_checker.f */
hdl/ota_pkg.sv
hdl/ota_rsq.sv
hdl/ota_core.sv
hdl/ota_session_checker.sv
verif/ota_session_checker_tb.sv
